### rtl/pca_pkg.sv
package pca_pkg;

    localparam int STANDARD_COLORS = 32;
    localparam int USER_COLORS     = 512;

    localparam int STD_AW  = (STANDARD_COLORS > 1) ? $clog2(STANDARD_COLORS) : 1;
    localparam int USR_AW  = (USER_COLORS > 1) ? $clog2(USER_COLORS) : 1;
    localparam int CNT_W   = $clog2(USER_COLORS + 1);
    localparam int STDC_W  = $clog2(STANDARD_COLORS + 1);
    localparam int SCAN_W  = (CNT_W > STDC_W) ? CNT_W : STDC_W;
    localparam int SLOT_CMP_W = 9;

    localparam int RGB_W   = 24;
    localparam int DIST_W  = 18;

    localparam logic [1:0] REG_QUANTIZE_MODE = 2'd0;
    localparam logic [1:0] REG_STD_BASE      = 2'd1;
    localparam logic [1:0] REG_USER_BASE     = 2'd2;

    localparam logic [9:0] USER_BASE_RST = 10'd32;

    typedef enum logic [2:0] {
        OC_STD_MATCH  = 3'd0,
        OC_USER_MATCH = 3'd1,
        OC_ADDED      = 3'd2,
        OC_QUANTIZED  = 3'd3,
        OC_FULL       = 3'd4,
        OC_LOADED     = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_STD_SCAN,
        ST_USER_SCAN
    } state_t;

    typedef struct packed {
        logic        action;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [4:0]  palette_slot;
    } in_word_t;

    typedef struct packed {
        logic signed [11:0] color_index;
        outcome_t           outcome;
    } out_word_t;

    typedef struct packed {
        logic     capture;
        logic     load;
        logic     scan_start;
        logic     scan_user;
        logic     append;
        logic     emit;
        outcome_t outcome;
    } cmd_t;

    typedef struct packed {
        logic action;
        logic quant;
        logic scan_done;
        logic found;
        logic full;
    } status_t;

endpackage

### rtl/pca_ctrl.sv
module pca_ctrl
    import pca_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.action)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_STD_SCAN;
                end
            end
            ST_STD_SCAN:
            begin
                if (status.scan_done)
                begin
                    if (status.quant || status.found)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_USER_SCAN;
                    end
                end
            end
            ST_USER_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_DISPATCH:
            begin
                if (status.action)
                begin
                    cmd.load    = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.outcome = OC_LOADED;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                end
            end
            ST_STD_SCAN:
            begin
                if (status.scan_done)
                begin
                    if (status.quant)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.outcome = OC_QUANTIZED;
                    end
                    else if (status.found)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.outcome = OC_STD_MATCH;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_user  = 1'b1;
                    end
                end
            end
            ST_USER_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.emit = 1'b1;
                    if (status.found)
                    begin
                        cmd.outcome = OC_USER_MATCH;
                    end
                    else if (status.full)
                    begin
                        cmd.outcome = OC_FULL;
                    end
                    else
                    begin
                        cmd.append  = 1'b1;
                        cmd.outcome = OC_ADDED;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/pca_dpath.sv
module pca_dpath
    import pca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  request,
    input  logic      cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data,
    input  cmd_t      cmd,
    output status_t   status,
    output logic      done,
    output out_word_t result
);

    logic             quant_reg;
    logic [9:0]       std_base_reg;
    logic [9:0]       user_base_reg;

    logic             action_reg;
    logic [4:0]       slot_reg;
    logic [RGB_W-1:0] rgb_reg;

    logic [RGB_W-1:0] std_mem  [STANDARD_COLORS];
    logic [RGB_W-1:0] user_mem [USER_COLORS];
    logic [RGB_W-1:0] std_q_reg;
    logic [RGB_W-1:0] user_q_reg;

    logic [CNT_W-1:0] user_count_reg;

    logic              scan_busy_reg;
    logic              scan_user_reg;
    logic [SCAN_W-1:0] issue_idx_reg;
    logic [SCAN_W-1:0] scan_limit;
    logic              issuing;
    logic              scan_done;

    logic              p1_vld_reg;
    logic [SCAN_W-1:0] p1_idx_reg;
    logic              p2_vld_reg;
    logic [SCAN_W-1:0] p2_idx_reg;
    logic              p2_eq_reg;
    logic [15:0]       sq_r_reg;
    logic [15:0]       sq_g_reg;
    logic [15:0]       sq_b_reg;

    logic [RGB_W-1:0]  q_sel;
    logic [7:0]        d_r;
    logic [7:0]        d_g;
    logic [7:0]        d_b;
    logic [DIST_W-1:0] dist_sum;

    logic              found_reg;
    logic [SCAN_W-1:0] best_idx_reg;
    logic [DIST_W-1:0] best_d_reg;

    logic              full;
    logic [11:0]       index_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_reg     <= 1'b0;
            std_base_reg  <= '0;
            user_base_reg <= USER_BASE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_QUANTIZE_MODE: quant_reg     <= cfg_data[0];
                REG_STD_BASE:      std_base_reg  <= cfg_data;
                REG_USER_BASE:     user_base_reg <= cfg_data;
                default:           quant_reg     <= quant_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= request.action;
            slot_reg   <= request.palette_slot;
            rgb_reg    <= {request.red[15:8], request.green[15:8], request.blue[15:8]};
        end
    end

    // palette stores
    always_ff @(posedge clk)
    begin
        if (cmd.load && (SLOT_CMP_W'(slot_reg) < SLOT_CMP_W'(STANDARD_COLORS)))
        begin
            std_mem[STD_AW'(slot_reg)] <= rgb_reg;
        end
        std_q_reg <= std_mem[STD_AW'(issue_idx_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            user_mem[USR_AW'(user_count_reg)] <= rgb_reg;
        end
        user_q_reg <= user_mem[USR_AW'(issue_idx_reg)];
    end

    assign full = (user_count_reg >= CNT_W'(USER_COLORS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_count_reg <= '0;
        end
        else if (cmd.append)
        begin
            user_count_reg <= user_count_reg + CNT_W'(1);
        end
    end

    // scan sequencer
    assign scan_limit = scan_user_reg ? SCAN_W'(user_count_reg) : SCAN_W'(STANDARD_COLORS);
    assign issuing    = scan_busy_reg && (issue_idx_reg < scan_limit);
    assign scan_done  = scan_busy_reg && !issuing && !p1_vld_reg && !p2_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_busy_reg <= 1'b0;
            scan_user_reg <= 1'b0;
            issue_idx_reg <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                scan_busy_reg <= 1'b1;
                scan_user_reg <= cmd.scan_user;
                issue_idx_reg <= '0;
            end
            else
            begin
                if (scan_done)
                begin
                    scan_busy_reg <= 1'b0;
                end
                if (issuing)
                begin
                    issue_idx_reg <= issue_idx_reg + SCAN_W'(1);
                end
            end
            p1_vld_reg <= issuing && !cmd.scan_start;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    assign q_sel = scan_user_reg ? user_q_reg : std_q_reg;
    assign d_r = (q_sel[23:16] > rgb_reg[23:16]) ? q_sel[23:16] - rgb_reg[23:16]
                                                 : rgb_reg[23:16] - q_sel[23:16];
    assign d_g = (q_sel[15:8] > rgb_reg[15:8]) ? q_sel[15:8] - rgb_reg[15:8]
                                               : rgb_reg[15:8] - q_sel[15:8];
    assign d_b = (q_sel[7:0] > rgb_reg[7:0]) ? q_sel[7:0] - rgb_reg[7:0]
                                             : rgb_reg[7:0] - q_sel[7:0];

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= issue_idx_reg;
        p2_idx_reg <= p1_idx_reg;
        p2_eq_reg  <= (q_sel == rgb_reg);
        sq_r_reg   <= 16'(d_r) * 16'(d_r);
        sq_g_reg   <= 16'(d_g) * 16'(d_g);
        sq_b_reg   <= 16'(d_b) * 16'(d_b);
    end

    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    // first hit in match mode, first minimum in quantize mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            found_reg <= 1'b0;
        end
        else if (p2_vld_reg)
        begin
            if (quant_reg)
            begin
                found_reg <= 1'b1;
            end
            else if (p2_eq_reg)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_vld_reg && !cmd.scan_start)
        begin
            if (quant_reg)
            begin
                if (!found_reg || (dist_sum < best_d_reg))
                begin
                    best_idx_reg <= p2_idx_reg;
                    best_d_reg   <= dist_sum;
                end
            end
            else if (p2_eq_reg && !found_reg)
            begin
                best_idx_reg <= p2_idx_reg;
            end
        end
    end

    // result word
    always_comb
    begin
        case (cmd.outcome)
            OC_LOADED:
                index_next = {2'b00, std_base_reg} + 12'(slot_reg);
            OC_STD_MATCH, OC_QUANTIZED:
                index_next = {2'b00, std_base_reg} + 12'(best_idx_reg);
            OC_USER_MATCH:
                index_next = {2'b00, user_base_reg} + 12'(best_idx_reg);
            OC_ADDED:
                index_next = {2'b00, user_base_reg} + 12'(user_count_reg);
            OC_FULL:
                index_next = '1;
            default:
                index_next = '1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result.color_index <= $signed(index_next);
            result.outcome     <= cmd.outcome;
        end
    end

    assign status.action    = action_reg;
    assign status.quant     = quant_reg;
    assign status.scan_done = scan_done;
    assign status.found     = found_reg;
    assign status.full      = full;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        user_count_reg <= CNT_W'(USER_COLORS))
        else $error("user count beyond table size");

    a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !full)
        else $error("append into full user table");

    a_user_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && scan_user_reg && !quant_reg) |-> (SCAN_W'(user_count_reg) > best_idx_reg))
        else $error("user hit beyond fill level");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> (scan_busy_reg && issue_idx_reg == '0 && !p1_vld_reg))
        else $error("scan start did not clear sequencer");
`endif

endmodule

### rtl/palette_color_index_allocator.sv
// A load needs no scan; quantize or a standard hit scans only the standard table; a match
// that misses there also scans the user table up to its fill level, with one read per cycle.
// Throughput: one word at a time; busy stays high from accept until the result strobe.
// The result stands for one cycle with done high; the receiver cannot stall.
// Reset (rst_n, async, low): empty user table, quantize off, bases 0 and 32.
module palette_color_index_allocator
    import pca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_word_t   request,
    output logic       done,
    output out_word_t  result,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    pca_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    pca_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

### tb/palette_index_checker.sv
module palette_index_checker
    import pca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  in_word_t   request,
    input  logic       done,
    input  out_word_t  result,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data,
    output int         fails,
    output int         pending,
    output int         checked,
    output logic [5:0] outcome_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        quant;
    logic [9:0]  std_base;
    logic [9:0]  user_base;
    logic [23:0] std_pal [STANDARD_COLORS];
    logic [23:0] usr_pal [USER_COLORS];
    int          usr_cnt;
    out_word_t   index_due [$];

    task automatic report_mismatch(input string msg);
        fails++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int unsigned colour_distance(input logic [23:0] a,
                                                     input logic [23:0] b);
        int unsigned sum;
        int ca;
        int cb;
        int d;
        sum = 0;
        for (int s = 0; s < 24; s += 8) begin
            ca = a[s +: 8];
            cb = b[s +: 8];
            d = (ca > cb) ? ca - cb : cb - ca;
            sum += d * d;
        end
        return sum;
    endfunction

    // updates the palette copies as the block would
    task automatic predict_index(input in_word_t w, output out_word_t r);
        logic [23:0] rgb;
        int unsigned best_d;
        int unsigned d;
        int best;
        bit hit;
        rgb = {w.red[15:8], w.green[15:8], w.blue[15:8]};
        hit = 1'b0;
        r.color_index = '0;
        r.outcome = OC_LOADED;
        if (w.action) begin
            if (w.palette_slot < STANDARD_COLORS)
                std_pal[w.palette_slot] = rgb;
            r.color_index = {2'b00, std_base} + {7'b0, w.palette_slot};
            r.outcome = OC_LOADED;
        end else if (quant) begin
            best = 0;
            best_d = colour_distance(std_pal[0], rgb);
            for (int i = 1; i < STANDARD_COLORS; i++) begin
                d = colour_distance(std_pal[i], rgb);
                if (d < best_d) begin
                    best_d = d;
                    best = i;
                end
            end
            r.color_index = {2'b00, std_base} + best[11:0];
            r.outcome = OC_QUANTIZED;
        end else begin
            for (int i = 0; i < STANDARD_COLORS && !hit; i++) begin
                if (std_pal[i] == rgb) begin
                    hit = 1'b1;
                    r.color_index = {2'b00, std_base} + i[11:0];
                    r.outcome = OC_STD_MATCH;
                end
            end
            for (int i = 0; i < usr_cnt && !hit; i++) begin
                if (usr_pal[i] == rgb) begin
                    hit = 1'b1;
                    r.color_index = {2'b00, user_base} + i[11:0];
                    r.outcome = OC_USER_MATCH;
                end
            end
            if (!hit) begin
                if (usr_cnt >= USER_COLORS) begin
                    r.color_index = -12'sd1;
                    r.outcome = OC_FULL;
                end else begin
                    usr_pal[usr_cnt] = rgb;
                    r.color_index = {2'b00, user_base} + usr_cnt[11:0];
                    r.outcome = OC_ADDED;
                    usr_cnt++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_word_t want;
        if (!rst_n) begin
            quant = 1'b0;
            std_base = '0;
            user_base = USER_BASE_RST;
            usr_cnt = 0;
            for (int i = 0; i < STANDARD_COLORS; i++)
                std_pal[i] = '0;
            index_due.delete();
            fails = 0;
            checked = 0;
            pending <= 0;
            outcome_seen <= '0;
        end else begin
            // compare before predicting: a result and a new word may share an edge
            if (done) begin
                checked++;
                if (result.outcome <= OC_LOADED)
                    outcome_seen[result.outcome] <= 1'b1;
                if (index_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d with no word outstanding",
                                              result.color_index, result.outcome));
                end else begin
                    want = index_due.pop_front();
                    if (result.color_index !== want.color_index)
                        report_mismatch($sformatf("color_index %0d, expected %0d",
                                                  result.color_index, want.color_index));
                    if (result.outcome !== want.outcome)
                        report_mismatch($sformatf("outcome %0d, expected %0d",
                                                  result.outcome, want.outcome));
                end
            end
            if (cfg_write) begin
                case (cfg_index)
                    REG_QUANTIZE_MODE: quant = cfg_data[0];
                    REG_STD_BASE:      std_base = cfg_data;
                    REG_USER_BASE:     user_base = cfg_data;
                    default:           ;
                endcase
            end
            if (start && !busy) begin
                predict_index(request, want);
                index_due.push_back(want);
            end
            pending <= index_due.size();
        end
    end

endmodule

### tb/tb.sv
module tb
    import pca_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 10_000_000;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_word_t   request;
    logic       done;
    out_word_t  result;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [9:0] cfg_data;

    int         fails;
    int         pending;
    int         checked;
    logic [5:0] outcome_seen;

    int          words_sent;
    int          loads_sent;
    int          reg_writes;
    int          cycles;
    logic [23:0] std_shadow [STANDARD_COLORS];
    logic [23:0] recent_colours [$];

    palette_color_index_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    palette_index_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .done         (done),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .pending      (pending),
        .checked      (checked),
        .outcome_seen (outcome_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [23:0] any_colour();
        logic [31:0] r;
        r = $urandom;
        return r[23:0];
    endfunction

    // low bytes of each channel are dropped by the block, so they are random
    function automatic in_word_t make_word(input logic act, input logic [23:0] rgb,
                                           input logic [4:0] slot);
        in_word_t w;
        w.action = act;
        w.red = {rgb[23:16], 8'h00};
        w.green = {rgb[15:8], 8'h00};
        w.blue = {rgb[7:0], 8'h00};
        w.red[7:0] = 8'($urandom_range(0, 255));
        w.green[7:0] = 8'($urandom_range(0, 255));
        w.blue[7:0] = 8'($urandom_range(0, 255));
        w.palette_slot = slot;
        return w;
    endfunction

    task automatic drive_word(input in_word_t w);
        @(negedge clk);
        start <= 1'b1;
        request <= w;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
        if (w.action)
            loads_sent++;
    endtask

    task automatic idle_gap();
        int sel;
        int n;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            n = $urandom_range(0, 3);
        else if (sel < 8)
            n = $urandom_range(4, 60);
        else
            n = $urandom_range(61, 700);
        @(negedge clk);
        start <= 1'b0;
        request <= make_word(1'($urandom_range(0, 1)), any_colour(),
                             5'($urandom_range(0, 31)));
        repeat (n) @(negedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        reg_writes++;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_setting(input logic q, input logic [9:0] sb, input logic [9:0] ub,
                                 input bit poke_unused);
        logic [9:0] d;
        settle();
        d = 10'($urandom_range(0, 1023));
        d[0] = q;
        write_reg(REG_QUANTIZE_MODE, d);
        write_reg(REG_STD_BASE, sb);
        write_reg(REG_USER_BASE, ub);
        if (poke_unused)
            write_reg(REG_UNUSED, 10'($urandom_range(0, 1023)));
        end_writes();
    endtask

    task automatic run_phase(input bit quant, input int n, input int fresh_pct,
                             input bit to_full);
        in_word_t    w;
        int          k;
        int          tail;
        int          burst;
        int          sel;
        logic [23:0] c;
        logic [23:0] nudge;
        logic [4:0]  slot;
        k = 0;
        tail = 0;
        burst = $urandom_range(1, 12);
        while (k < n || (to_full && tail < 20 && k < 1500))
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                slot = 5'($urandom_range(0, 31));
                if ($urandom_range(0, 2) == 0)
                    c = std_shadow[5'($urandom_range(0, 31))];
                else
                    c = any_colour();
                std_shadow[slot] = c;
                w = make_word(1'b1, c, slot);
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < fresh_pct)
                    c = any_colour();
                else if (quant || recent_colours.size() == 0
                         || sel < fresh_pct + (100 - fresh_pct) / 2)
                begin
                    c = std_shadow[5'($urandom_range(0, 31))];
                    if (quant)
                    begin
                        nudge = 24'($urandom_range(0, 7));
                        c = c ^ (nudge << (8 * $urandom_range(0, 2)));
                    end
                end
                else
                    c = recent_colours[$urandom_range(0, recent_colours.size() - 1)];
                if (!quant)
                begin
                    recent_colours.push_back(c);
                    if (recent_colours.size() > 64)
                        void'(recent_colours.pop_front());
                end
                w = make_word(1'b0, c, 5'($urandom_range(0, 31)));
            end
            drive_word(w);
            k++;
            if (to_full && outcome_seen[OC_FULL])
                tail++;
            burst--;
            if (burst == 0)
            begin
                idle_gap();
                burst = $urandom_range(1, 12);
            end
        end
    endtask

    initial
    begin
        in_word_t    w;
        logic [23:0] match_list [8];
        logic [23:0] quant_list [5];
        start = 1'b0;
        request = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        words_sent = 0;
        loads_sent = 0;
        reg_writes = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unused register index must not disturb the reset values
        settle();
        write_reg(REG_UNUSED, 10'h3ff);
        end_writes();

        // whole standard palette first; black and red 0x02 make a tie for quantize
        std_shadow[0] = 24'hffffff;
        std_shadow[1] = 24'h000000;
        std_shadow[2] = 24'h020000;
        for (int i = 3; i < STANDARD_COLORS; i++)
            std_shadow[i] = {8'($urandom_range(8'h40, 8'hff)), 16'($urandom)};
        std_shadow[30] = std_shadow[3];
        std_shadow[31] = 24'h807f01;
        for (int i = 0; i < STANDARD_COLORS; i++)
        begin
            w = make_word(1'b1, std_shadow[i], i[4:0]);
            if (i == 0)
                {w.red, w.green, w.blue} = {48{1'b1}};
            if (i == 1)
                {w.red, w.green, w.blue} = '0;
            drive_word(w);
        end

        match_list = '{24'hffffff, 24'h000000, std_shadow[3], 24'h123456,
                       24'h123456, 24'habcdef, std_shadow[31], 24'habcdef};
        foreach (match_list[i])
        begin
            drive_word(make_word(1'b0, match_list[i], 5'($urandom_range(0, 31))));
            recent_colours.push_back(match_list[i]);
        end

        apply_setting(1'b1, 10'd0, 10'd32, 1'b0);
        quant_list = '{24'h010000, std_shadow[3], 24'hffffff, 24'h7f7f7f, 24'h000000};
        foreach (quant_list[i])
            drive_word(make_word(1'b0, quant_list[i], 5'($urandom_range(0, 31))));

        apply_setting(1'b0, 10'd0, 10'd32, 1'b1);
        run_phase(1'b0, 100, 70, 1'b0);
        apply_setting(1'b1, 10'd1023, 10'($urandom_range(0, 1023)), 1'b0);
        run_phase(1'b1, 50, 60, 1'b0);
        apply_setting(1'b0, 10'($urandom_range(0, 1023)), 10'd1023, 1'b0);
        run_phase(1'b0, 100, 70, 1'b0);
        apply_setting(1'b1, 10'd0, 10'($urandom_range(0, 1023)), 1'b0);
        run_phase(1'b1, 50, 60, 1'b0);
        // mostly new colours until the user table runs out, then a mixed tail
        apply_setting(1'b0, 10'($urandom_range(0, 1023)), 10'd0, 1'b1);
        run_phase(1'b0, 150, 90, 1'b1);

        settle();
        repeat (20) @(posedge clk);

        $display("Summary: %0d words sent (%0d palette loads), %0d results checked",
                 words_sent, loads_sent, checked);
        $display("Summary: %0d reg writes, outcome codes seen %b (bit n is code n), %0d cycles",
                 reg_writes, outcome_seen, cycles);
        if (fails == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/pca_pkg.sv
rtl/pca_ctrl.sv
rtl/pca_dpath.sv
rtl/palette_color_index_allocator.sv
tb/palette_index_checker.sv
tb/tb.sv
